/* sv/bisl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boot image section loader package
// Shared widths, header constants, result codes and the result record.
// ----------------------------------------------------------------------------
package bisl_pkg;

  localparam int WORD_W        = 32;
  localparam int IMAGE_BYTES_W = 21;
  localparam int POS_W         = 19;
  localparam int KIND_W        = 2;
  localparam int ERR_W         = 3;
  localparam int PADDR_W       = 3;

  localparam logic [IMAGE_BYTES_W-1:0] MAX_IMAGE_BYTES = IMAGE_BYTES_W'(512 * 1024);
  localparam logic [POS_W-1:0]         POS_MAX         = '1;

  localparam logic [7:0] SIG_BYTE0    = 8'h43;
  localparam logic [7:0] SIG_BYTE1    = 8'h59;
  localparam logic [7:0] NO_CODE_MASK = 8'h01;
  localparam logic [7:0] CKSUM_FORMAT = 8'hB0;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

  localparam logic [ERR_W-1:0] ERR_TOO_LARGE    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SIG      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_CODE      = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_CKSUM_FMT = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CKSUM        = 3'd4;

  localparam logic [PADDR_W-1:0] ADDR_IMAGE_BYTES = 3'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] target_address;
    logic [WORD_W-1:0] write_data;
    logic [ERR_W-1:0]  error_code;
    logic              last_of_run;
  } result_t;

endpackage
`default_nettype wire

/* sv/bisl_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boot image section loader channels
// Valid/ready channels for image words in and loader results out.
// ----------------------------------------------------------------------------
interface bisl_in_if;
  import bisl_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] image_word;
  logic              first_word;
  modport source (output valid, image_word, first_word, input ready);
  modport sink (input valid, image_word, first_word, output ready);
endinterface

interface bisl_out_if;
  import bisl_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] target_address;
  logic [WORD_W-1:0] write_data;
  logic [ERR_W-1:0]  error_code;
  logic              last_of_run;
  modport source (output valid, kind, target_address, write_data, error_code, last_of_run,
                  input ready);
  modport sink (input valid, kind, target_address, write_data, error_code, last_of_run,
                output ready);
endinterface
`default_nettype wire

/* sv/boot_image_section_loader_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Boot image section loader core
// Parses a sectioned boot image word by word into memory writes and a final
// entry jump, error or end report.
// ----------------------------------------------------------------------------
// The loader takes one image word per clock cycle while its result queue has
// room and handles it completely in the cycle it is accepted, placing its
// results in a four-entry result queue. A word causes at most two results, so
// a request is accepted whenever the queue has two free entries; with the
// result side always ready the block sustains one word per cycle, and a word
// that ends a section at the end of the image writes two results to the queue.
module boot_image_section_loader_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bisl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  bisl_in_if.sink                           image_in,
  bisl_out_if.source                        result_out
);
  import bisl_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_ADDRESS,
    PH_DATA,
    PH_CHECKSUM,
    PH_DONE
  } phase_t;

  logic [IMAGE_BYTES_W-1:0] image_bytes;
  phase_t                   phase, phase_next;
  logic [POS_W-1:0]         word_position, word_position_next;
  logic [WORD_W-1:0]        words_left, words_left_next;
  logic [WORD_W-1:0]        write_address, write_address_next;
  logic [WORD_W-1:0]        running_sum, running_sum_next;
  logic [WORD_W-1:0]        entry_address, entry_address_next;

  result_t               queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]     count;

  result_t     res0, res1;
  logic [1:0]  num_res;
  logic        in_fire, out_fire;
  logic [7:0]  b0, b1, b2, b3;
  logic [POS_W-1:0] pos_adv;
  logic [WORD_W-1:0] words_dec;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr == ADDR_IMAGE_BYTES) ? {{(32 - IMAGE_BYTES_W){1'b0}}, image_bytes}
                                                 : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes <= '0;
    end else if (cfg_write && paddr == ADDR_IMAGE_BYTES) begin
      image_bytes <= pwdata[IMAGE_BYTES_W-1:0];
    end
  end

  assign image_in.ready = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_fire        = image_in.valid && image_in.ready;
  assign out_fire       = result_out.valid && result_out.ready;

  assign b0 = image_in.image_word[7:0];
  assign b1 = image_in.image_word[15:8];
  assign b2 = image_in.image_word[23:16];
  assign b3 = image_in.image_word[31:24];
  assign pos_adv   = (word_position == POS_MAX) ? word_position : word_position + 1'b1;
  assign words_dec = words_left - 1'b1;

  always_comb begin
    phase_next         = phase;
    word_position_next = word_position;
    words_left_next    = words_left;
    write_address_next = write_address;
    running_sum_next   = running_sum;
    entry_address_next = entry_address;
    res0    = '0;
    res1    = '0;
    num_res = 2'd0;
    if (image_in.first_word) begin
      word_position_next = POS_W'(1);
      words_left_next    = '0;
      write_address_next = '0;
      running_sum_next   = '0;
      entry_address_next = '0;
      phase_next         = PH_DONE;
      num_res            = 2'd1;
      res0.kind          = KIND_ERROR;
      if (image_bytes > MAX_IMAGE_BYTES) begin
        res0.error_code = ERR_TOO_LARGE;
      end else if (b0 != SIG_BYTE0 || b1 != SIG_BYTE1) begin
        res0.error_code = ERR_BAD_SIG;
      end else if ((b2 & NO_CODE_MASK) != 8'd0) begin
        res0.error_code = ERR_NO_CODE;
      end else if (b3 != CKSUM_FORMAT) begin
        res0.error_code = ERR_NO_CKSUM_FMT;
      end else if (IMAGE_BYTES_W'(4) >= image_bytes) begin
        res0.kind = KIND_END;
      end else begin
        num_res    = 2'd0;
        res0       = '0;
        phase_next = PH_LENGTH;
      end
    end else begin
      case (phase)
        PH_LENGTH: begin
          word_position_next = pos_adv;
          words_left_next    = image_in.image_word;
          phase_next         = PH_ADDRESS;
        end
        PH_ADDRESS: begin
          word_position_next = pos_adv;
          if (words_left == '0) begin
            entry_address_next = image_in.image_word;
            phase_next         = PH_CHECKSUM;
          end else begin
            write_address_next = image_in.image_word;
            phase_next         = PH_DATA;
          end
        end
        PH_DATA: begin
          word_position_next  = pos_adv;
          num_res             = 2'd1;
          res0.kind           = KIND_WRITE;
          res0.target_address = write_address;
          res0.write_data     = image_in.image_word;
          running_sum_next    = running_sum + image_in.image_word;
          write_address_next  = write_address + WORD_W'(4);
          words_left_next     = words_dec;
          if (words_dec == '0) begin
            if ({pos_adv, 2'b00} >= image_bytes) begin
              num_res    = 2'd2;
              res1.kind  = KIND_END;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_LENGTH;
            end
          end
        end
        PH_CHECKSUM: begin
          word_position_next = pos_adv;
          num_res            = 2'd1;
          if (image_in.image_word == running_sum) begin
            res0.kind           = KIND_ENTRY;
            res0.target_address = entry_address;
          end else begin
            res0.kind       = KIND_ERROR;
            res0.error_code = ERR_CKSUM;
          end
          phase_next = PH_DONE;
        end
        default: begin
        end
      endcase
    end
    if (num_res == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = (num_res == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      word_position <= '0;
      words_left    <= '0;
      write_address <= '0;
      running_sum   <= '0;
      entry_address <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      word_position <= word_position_next;
      words_left    <= words_left_next;
      write_address <= write_address_next;
      running_sum   <= running_sum_next;
      entry_address <= entry_address_next;
    end
  end

  // Result queue: up to two results written per request, one read per ready cycle.
  always_ff @(posedge clk) begin
    if (in_fire && num_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && num_res == 2'd2) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(num_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_fire ? QCNT_W'(num_res) : QCNT_W'(0))
                     - (out_fire ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  assign result_out.valid          = (count != '0);
  assign result_out.kind           = queue[rd_ptr].kind;
  assign result_out.target_address = queue[rd_ptr].target_address;
  assign result_out.write_data     = queue[rd_ptr].write_data;
  assign result_out.error_code     = queue[rd_ptr].error_code;
  assign result_out.last_of_run    = queue[rd_ptr].last_of_run;

endmodule
`default_nettype wire

/* tb/bisl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image section loader result checker
// Watches the configuration port and both channels, runs its own parser of
// the image stream to work out the memory writes, entry jumps, errors and
// end reports that each accepted request causes, and compares every result
// with the oldest one still expected.
// ----------------------------------------------------------------------------
module bisl_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [bisl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  bisl_in_if                           image_mon,
  bisl_out_if                          result_mon,
  output int                           outstanding,
  output int                           fail_count
);
  import bisl_pkg::*;

  typedef enum logic [2:0] {
    WAIT_HEADER,
    READ_LENGTH,
    READ_ADDRESS,
    READ_DATA,
    READ_SUM,
    PARSE_DONE
  } parse_state_t;

  logic [IMAGE_BYTES_W-1:0] image_bytes;
  parse_state_t             parse_state;
  logic [POS_W-1:0]         word_pos;
  logic [WORD_W-1:0]        words_left;
  logic [WORD_W-1:0]        write_addr;
  logic [WORD_W-1:0]        word_sum;
  logic [WORD_W-1:0]        entry_addr;
  int                       caused;
  result_t                  expected_results[$];

  function automatic logic image_ended();
    return {word_pos, 2'b00} >= image_bytes;
  endfunction

  function automatic void advance_pos();
    if (word_pos != POS_MAX) begin
      word_pos = word_pos + 1'b1;
    end
  endfunction

  function automatic void add_result(input logic [KIND_W-1:0] kind,
                                     input logic [WORD_W-1:0] addr,
                                     input logic [WORD_W-1:0] data,
                                     input logic [ERR_W-1:0]  code);
    result_t r;
    r.kind           = kind;
    r.target_address = addr;
    r.write_data     = data;
    r.error_code     = code;
    r.last_of_run    = 1'b0;
    expected_results.push_back(r);
    caused++;
  endfunction

  function automatic void parse_word(input logic [WORD_W-1:0] w, input logic hdr);
    caused = 0;
    if (hdr) begin
      word_pos    = POS_W'(1);
      words_left  = '0;
      write_addr  = '0;
      word_sum    = '0;
      entry_addr  = '0;
      parse_state = PARSE_DONE;
      if (image_bytes > MAX_IMAGE_BYTES) begin
        add_result(KIND_ERROR, '0, '0, ERR_TOO_LARGE);
      end else if (w[7:0] != SIG_BYTE0 || w[15:8] != SIG_BYTE1) begin
        add_result(KIND_ERROR, '0, '0, ERR_BAD_SIG);
      end else if ((w[23:16] & NO_CODE_MASK) != '0) begin
        add_result(KIND_ERROR, '0, '0, ERR_NO_CODE);
      end else if (w[31:24] != CKSUM_FORMAT) begin
        add_result(KIND_ERROR, '0, '0, ERR_NO_CKSUM_FMT);
      end else if (image_ended()) begin
        add_result(KIND_END, '0, '0, ERR_TOO_LARGE);
      end else begin
        parse_state = READ_LENGTH;
      end
    end else begin
      case (parse_state)
        READ_LENGTH: begin
          advance_pos();
          words_left  = w;
          parse_state = READ_ADDRESS;
        end
        READ_ADDRESS: begin
          advance_pos();
          if (words_left == '0) begin
            entry_addr  = w;
            parse_state = READ_SUM;
          end else begin
            write_addr  = w;
            parse_state = READ_DATA;
          end
        end
        READ_DATA: begin
          advance_pos();
          add_result(KIND_WRITE, write_addr, w, ERR_TOO_LARGE);
          word_sum   = word_sum + w;
          write_addr = write_addr + 32'd4;
          words_left = words_left - 1'b1;
          if (words_left == '0) begin
            if (image_ended()) begin
              add_result(KIND_END, '0, '0, ERR_TOO_LARGE);
              parse_state = PARSE_DONE;
            end else begin
              parse_state = READ_LENGTH;
            end
          end
        end
        READ_SUM: begin
          advance_pos();
          if (w == word_sum) begin
            add_result(KIND_ENTRY, entry_addr, '0, ERR_TOO_LARGE);
          end else begin
            add_result(KIND_ERROR, '0, '0, ERR_CKSUM);
          end
          parse_state = PARSE_DONE;
        end
        default: begin
        end
      endcase
    end
    if (caused > 0) begin
      expected_results[expected_results.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic void compare_result();
    result_t got;
    result_t want;
    got.kind           = result_mon.kind;
    got.target_address = result_mon.target_address;
    got.write_data     = result_mon.write_data;
    got.error_code     = result_mon.error_code;
    got.last_of_run    = result_mon.last_of_run;
    if (expected_results.size() == 0) begin
      if (fail_count < 10) begin
        $display("%0t: unexpected result kind=%0d addr=%h data=%h code=%0d last=%0b",
                 $time, got.kind, got.target_address, got.write_data, got.error_code,
                 got.last_of_run);
      end
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.target_address !== want.target_address ||
          got.write_data !== want.write_data || got.error_code !== want.error_code ||
          got.last_of_run !== want.last_of_run) begin
        if (fail_count < 10) begin
          $display("%0t: mismatch expected kind=%0d addr=%h data=%h code=%0d last=%0b",
                   $time, want.kind, want.target_address, want.write_data,
                   want.error_code, want.last_of_run);
          $display("%0t:          actual   kind=%0d addr=%h data=%h code=%0d last=%0b",
                   $time, got.kind, got.target_address, got.write_data, got.error_code,
                   got.last_of_run);
        end
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      image_bytes = '0;
      parse_state = WAIT_HEADER;
      word_pos    = '0;
      words_left  = '0;
      write_addr  = '0;
      word_sum    = '0;
      entry_addr  = '0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_IMAGE_BYTES) begin
        image_bytes = pwdata[IMAGE_BYTES_W-1:0];
      end
      if (image_mon.valid && image_mon.ready) begin
        parse_word(image_mon.image_word, image_mon.first_word);
      end
      if (result_mon.valid && result_mon.ready) begin
        compare_result();
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image section loader testbench
// Streams directed and random boot images (good images, truncated images,
// bad headers and stray words) through the loader under several image size
// settings, with bursty requests and a stalling result side, and reports the
// verdict of the result checker.
// ----------------------------------------------------------------------------
module tb;
  import bisl_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 outstanding;
  int                 fail_count;
  int                 burst_left;
  int                 words_sent;
  bit                 no_gaps;
  bit                 hold_request;
  int unsigned        image_bytes_now;

  int unsigned phase_bytes[9] = '{524288, 64, 37, 4096, 1048576, 13, 0, 524289, 200};
  int          phase_items[9] = '{100, 70, 60, 80, 15, 50, 15, 15, 60};

  bisl_in_if  image_ch ();
  bisl_out_if result_ch ();

  boot_image_section_loader_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .image_in   (image_ch),
    .result_out (result_ch)
  );

  bisl_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .image_mon   (image_ch),
    .result_mon  (result_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    result_ch.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 120;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          2: result_ch.ready <= ($urandom_range(0, 1) != 0);
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [WORD_W-1:0] good_header();
    logic [7:0] flags;
    flags = 8'($urandom()) & ~NO_CODE_MASK;
    return {CKSUM_FORMAT, flags, SIG_BYTE1, SIG_BYTE0};
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input logic hdr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (no_gaps) begin
        gap = 0;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: gap = 0;
          5: gap = $urandom_range(8, 20);
          default: gap = $urandom_range(1, 4);
        endcase
      end
      if (gap > 0) begin
        @(negedge clk);
        image_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    image_ch.valid      <= 1'b1;
    image_ch.image_word <= w;
    image_ch.first_word <= hdr;
    do @(posedge clk); while (!image_ch.ready);
    burst_left--;
    words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    image_ch.valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_image_bytes(input int unsigned value);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_IMAGE_BYTES;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    image_bytes_now = value;
  endtask

  task automatic send_image(input bit truncate);
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] data;
    int pos;
    int len;
    int sections;
    int k;
    sum = '0;
    send_word(good_header(), 1'b1);
    if (image_bytes_now > MAX_IMAGE_BYTES) begin
      return;
    end
    pos      = 1;
    sections = $urandom_range(0, 4);
    while (1) begin
      if (pos * 4 >= image_bytes_now) begin
        return;
      end
      if (sections == 0) begin
        break;
      end
      sections--;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = 32'hFFFF_FFF0 | ($urandom() & 32'hC);
        default: addr = $urandom();
      endcase
      send_word(32'(len), 1'b0);
      send_word(addr, 1'b0);
      pos += 2;
      for (k = 0; k < len; k++) begin
        if (truncate && $urandom_range(0, 5) == 0) begin
          return;
        end
        case ($urandom_range(0, 5))
          0: data = '0;
          1: data = '1;
          default: data = $urandom();
        endcase
        send_word(data, 1'b0);
        sum += data;
        pos++;
      end
    end
    send_word('0, 1'b0);
    send_word($urandom(), 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_word(sum + 32'($urandom_range(1, 255)), 1'b0);
    end else begin
      send_word(sum, 1'b0);
    end
  endtask

  initial begin
    logic [WORD_W-1:0] hdr;
    int p;
    int i;
    int stop_at;
    int choice;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    image_ch.valid      = 1'b0;
    image_ch.image_word = '0;
    image_ch.first_word = 1'b0;
    burst_left          = 0;
    words_sent          = 0;
    no_gaps             = 1'b0;
    hold_request        = 1'b0;
    image_bytes_now     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_image_bytes(4);
    send_word(good_header(), 1'b1);

    write_image_bytes(1048576);
    send_word(good_header(), 1'b1);
    send_word(32'h0000_0001, 1'b0);

    write_image_bytes(MAX_IMAGE_BYTES);
    send_word({CKSUM_FORMAT, 8'h00, SIG_BYTE1, 8'h00}, 1'b1);
    send_word({CKSUM_FORMAT, 8'h00, 8'h00, SIG_BYTE0}, 1'b1);
    send_word({CKSUM_FORMAT, NO_CODE_MASK, SIG_BYTE1, SIG_BYTE0}, 1'b1);
    send_word({8'hA0, 8'hFE, SIG_BYTE1, SIG_BYTE0}, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(good_header(), 1'b1);
    send_word(32'd2, 1'b0);
    send_word(32'hFFFF_FFFC, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(good_header(), 1'b1);
    send_word(32'd1, 1'b0);
    send_word(good_header(), 1'b1);
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'd5, 1'b0);

    write_image_bytes(17);
    send_word(good_header(), 1'b1);
    send_word(32'd2, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b0);

    for (p = 0; p < 9; p++) begin
      write_image_bytes(phase_bytes[p]);
      if (p == 0) begin
        no_gaps = 1'b1;
        send_word(good_header(), 1'b1);
        hold_request = 1'b1;
        repeat (3) send_image(1'b0);
        no_gaps = 1'b0;
        settle();
      end
      stop_at = words_sent + phase_items[p];
      while (words_sent < stop_at) begin
        choice = $urandom_range(0, 19);
        if (choice < 13) begin
          send_image(1'b0);
        end else if (choice < 15) begin
          send_image(1'b1);
        end else if (choice < 17) begin
          hdr = good_header();
          case ($urandom_range(0, 2))
            0: begin
              if ($urandom_range(0, 1) == 0) begin
                hdr[7:0] = hdr[7:0] ^ 8'($urandom_range(1, 255));
              end else begin
                hdr[15:8] = hdr[15:8] ^ 8'($urandom_range(1, 255));
              end
            end
            1: hdr[23:16] = hdr[23:16] | NO_CODE_MASK;
            default: hdr[31:24] = hdr[31:24] ^ 8'($urandom_range(1, 255));
          endcase
          send_word(hdr, 1'b1);
          repeat ($urandom_range(0, 2)) send_word($urandom(), 1'b0);
        end else begin
          repeat ($urandom_range(1, 5)) send_word($urandom(), ($urandom_range(0, 9) == 0));
        end
      end
    end

    @(negedge clk);
    image_ch.valid <= 1'b0;
    for (i = 0; i < 10000 && outstanding != 0; i++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
